/* hw/rtl/assert_macros.svh */
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
// implication checked on the following clock
`define ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

/* hw/rtl/shc_pkg.sv */
// ----------------------------------------------------------------------------
// shc_pkg
// Shared types and constants of the SHA-256 hash chain appender.
// ----------------------------------------------------------------------------
package shc_pkg;
    typedef struct packed {
        logic [31:0] agent;
        logic [31:0] action;
        logic [31:0] outcome;
        logic [63:0] stamp;
    } rec_t;

    typedef logic [31:0] word_t;
    typedef logic [255:0] hash_t;

    localparam hash_t SHA_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic word_t sha_k(input logic [5:0] i);
        word_t k;
        case (i)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic word_t rotr(input word_t x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [63:0] bswap64(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 8; i++) r[8*i +: 8] = v[56-8*i +: 8];
        return r;
    endfunction

    function automatic word_t bswap32(input word_t v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction
endpackage

/* hw/rtl/sha256_hash_chain_log_appender.sv */
// ----------------------------------------------------------------------------
// sha256_hash_chain_log_appender
// Appends log records to a SHA-256 hash chain.
// ----------------------------------------------------------------------------
// s_ channel: one record per transaction (agent, action, outcome, stamp).
// m_ channel: the record's sequence number and its 256-bit digest as four
// 64-bit words, byte 0 most significant.
// A record enters a two-entry queue; the hash engine takes it, runs 64
// rounds for each of the two message blocks with one round per cycle and a
// fold step after each block, all in the single round unit. It takes no new
// record until its last fold loads the output register and raises m_valid.
// The digest becomes the chain head for the next record; records are
// processed strictly in order.
// Reset clears the chain head to zero and the sequence to zero and
// empties the queue. A stalled receiver holds the result in the output
// register; the engine waits in its last fold while the queue still takes
// up to two further records.
// ----------------------------------------------------------------------------
module sha256_hash_chain_log_appender (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_agent_number,
    input  logic [31:0] s_action_number,
    input  logic signed [31:0] s_outcome_value,
    input  logic [63:0] s_stamp_ns,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_record_sequence,
    output logic [63:0] m_digest_word0,
    output logic [63:0] m_digest_word1,
    output logic [63:0] m_digest_word2,
    output logic [63:0] m_digest_word3
);
    import shc_pkg::*;

    rec_t         in_rec, q_rec;
    logic         q_valid, q_ready;
    logic [255:0] hash;

    assign in_rec = '{agent: s_agent_number, action: s_action_number,
                      outcome: s_outcome_value, stamp: s_stamp_ns};

    shc_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_data(in_rec),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_rec)
    );

    shc_engine u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .rec_valid(q_valid), .rec_ready(q_ready), .rec(q_rec),
        .res_valid(m_valid), .res_ready(m_ready),
        .res_seq(m_record_sequence), .res_hash(hash)
    );

    assign m_digest_word0 = hash[255:192];
    assign m_digest_word1 = hash[191:128];
    assign m_digest_word2 = hash[127:64];
    assign m_digest_word3 = hash[63:0];
endmodule

/* hw/rtl/shc_fifo.sv */
// ----------------------------------------------------------------------------
// shc_fifo
// Two-entry record queue between the intake and the hash engine.
// ----------------------------------------------------------------------------
module shc_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  shc_pkg::rec_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output shc_pkg::rec_t out_data
);
    import shc_pkg::*;

    rec_t       mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_data;
        end
    end
endmodule

/* hw/rtl/shc_engine.sv */
// ----------------------------------------------------------------------------
// shc_engine
// Iterative SHA-256 over the two message blocks of one record, one round a
// cycle, holding the chain head and sequence; result in an output register.
// ----------------------------------------------------------------------------
module shc_engine (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          rec_valid,
    output logic          rec_ready,
    input  shc_pkg::rec_t rec,
    output logic          res_valid,
    input  logic          res_ready,
    output logic [63:0]   res_seq,
    output logic [255:0]  res_hash
);
    import shc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RND  = 2'd1;
    localparam logic [1:0] ST_FOLD = 2'd2;

    logic [1:0]   st_reg, st_next;
    logic [5:0]   rnd_reg;
    logic         blk_reg;
    word_t        w_reg [16];
    hash_t        h_reg, v_reg;
    hash_t        head_reg;
    logic [63:0]  seq_reg;
    logic         ov_reg;
    logic [63:0]  oseq_reg;
    hash_t        ohash_reg;
    logic [63:0]  seq_sw, stamp_sw;

    word_t a, b, c, d, e, f, g, hh, t1, t2, wi, s0, s1, wnew;
    logic  start, fin;

    assign a = v_reg[255:224]; assign b = v_reg[223:192];
    assign c = v_reg[191:160]; assign d = v_reg[159:128];
    assign e = v_reg[127:96];  assign f = v_reg[95:64];
    assign g = v_reg[63:32];   assign hh = v_reg[31:0];
    assign wi = w_reg[0];

    assign seq_sw   = bswap64(seq_reg);
    assign stamp_sw = bswap64(rec.stamp);

    always_comb begin
        s0   = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1   = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = w_reg[0] + s0 + w_reg[9] + s1;
        t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
            + sha_k(rnd_reg) + wi;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
    end

    assign rec_ready = (st_reg == ST_IDLE);
    assign start     = rec_valid && rec_ready;
    assign fin       = (st_reg == ST_FOLD) && blk_reg && (!ov_reg || res_ready);
    assign res_valid = ov_reg;
    assign res_seq   = oseq_reg;
    assign res_hash  = ohash_reg;

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: if (start) st_next = ST_RND;
            ST_RND:  if (rnd_reg == 6'd63) st_next = ST_FOLD;
            ST_FOLD: begin
                if (!blk_reg) st_next = ST_RND;
                else if (fin) st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    hash_t hsum;
    always_comb begin
        for (int i = 0; i < 8; i++)
            hsum[32*i +: 32] = h_reg[32*i +: 32] + v_reg[32*i +: 32];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_IDLE;
            ov_reg   <= 1'b0;
            head_reg <= '0;
            seq_reg  <= '0;
        end else begin
            st_reg <= st_next;
            if (fin) begin
                ov_reg   <= 1'b1;
                head_reg <= hsum;
                seq_reg  <= seq_reg + 64'd1;
            end else if (res_ready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fin) begin
            oseq_reg  <= seq_reg;
            ohash_reg <= hsum;
        end
        if (start) begin
            rnd_reg <= 6'd0;
            blk_reg <= 1'b0;
            h_reg   <= SHA_IV;
            v_reg   <= SHA_IV;
            w_reg[0] <= seq_sw[63:32];
            w_reg[1] <= seq_sw[31:0];
            w_reg[2] <= stamp_sw[63:32];
            w_reg[3] <= stamp_sw[31:0];
            for (int i = 0; i < 8; i++) w_reg[4+i] <= head_reg[255-32*i -: 32];
            w_reg[12] <= bswap32(rec.agent);
            w_reg[13] <= bswap32(rec.action);
            w_reg[14] <= bswap32(rec.outcome);
            w_reg[15] <= 32'h80000000;
        end else if (st_reg == ST_RND) begin
            rnd_reg <= rnd_reg + 6'd1;
            v_reg <= {t1 + t2, a, b, c, d + t1, e, f, g};
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wnew;
        end else if (st_reg == ST_FOLD && !blk_reg) begin
            blk_reg <= 1'b1;
            h_reg   <= hsum;
            v_reg   <= hsum;
            for (int i = 0; i < 15; i++) w_reg[i] <= 32'h0;
            w_reg[15] <= 32'd480;
        end
    end
endmodule

/* hw/rtl/shc_checker.sv */
// ----------------------------------------------------------------------------
// shc_checker
// Port-level checks of the hash chain appender.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_record_sequence
);
    logic        seen_reg;
    logic [63:0] last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            seen_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid && m_ready) last_reg <= m_record_sequence;
    end

    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `ASSERT_NEXT(a_keep, aclk, aresetn, m_valid && !m_ready, $stable(m_record_sequence))
    `ASSERT_IMPL(a_seq, aclk, aresetn, m_valid && seen_reg, m_record_sequence == last_reg + 64'd1)
endmodule

bind sha256_hash_chain_log_appender shc_checker u_shc_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_record_sequence(m_record_sequence)
);

/* tb/tb_sha256_hash_chain_log_appender.sv */
// ----------------------------------------------------------------------------
// tb_sha256_hash_chain_log_appender
// Self-checking bench for the SHA-256 hash chain log appender. Records go in
// through the s_ channel with random gaps. A chain model in the bench hashes
// each accepted record against its own copy of the chain head and sequence.
// Results are compared field by field in order. The receiver stalls at
// random, and once it holds off for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sha256_hash_chain_log_appender;
    import shc_pkg::*;

    localparam int  N_RANDOM    = 1040;
    localparam int  LONG_HOLD   = 3000;
    localparam int  DRAIN_WAIT  = 200;
    localparam longint LIMIT    = 2000000;

    typedef struct {
        logic [31:0] agent;
        logic [31:0] action;
        logic [31:0] outcome;
        logic [63:0] stamp;
        logic [63:0] seq_exp;
    } stim_row_t;

    typedef struct {
        logic [63:0] seq;
        hash_t       digest;
    } entry_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_agent_number;
    logic [31:0] s_action_number;
    logic signed [31:0] s_outcome_value;
    logic [63:0] s_stamp_ns;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_record_sequence;
    logic [63:0] m_digest_word0;
    logic [63:0] m_digest_word1;
    logic [63:0] m_digest_word2;
    logic [63:0] m_digest_word3;

    sha256_hash_chain_log_appender u_top (.*);

    entry_t      pending_digests[$];
    logic [63:0] seen_seq[$];
    hash_t       model_head;
    logic [63:0] model_seq;
    int          n_errors;
    int          n_sent;
    int          n_checked;
    longint      cycle_count;
    bit          hold_off_req;
    bit          no_idle;

    stim_row_t directed[] = '{
        '{32'h0, 32'h0, 32'h0, 64'h0, 64'd0},
        '{32'hffffffff, 32'hffffffff, 32'hffffffff, 64'hffffffffffffffff, 64'd1},
        '{32'h0, 32'h0, 32'h80000000, 64'h0, 64'd2},
        '{32'h0, 32'h0, 32'h7fffffff, 64'h0, 64'd3},
        '{32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 64'h5555555555555555, 64'd4},
        '{32'h55555555, 32'haaaaaaaa, 32'h55555555, 64'haaaaaaaaaaaaaaaa, 64'd5},
        '{32'h1, 32'h0, 32'h0, 64'h0, 64'd6},
        '{32'h0, 32'h1, 32'h0, 64'h1, 64'd7},
        '{32'h80000000, 32'h80000000, 32'h1, 64'h8000000000000000, 64'd8},
        '{32'h0, 32'h0, 32'h0, 64'h0, 64'd9}
    };

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic hash_t compress(hash_t h_in, logic [511:0] blk);
        logic [31:0] w[64];
        logic [31:0] v[8];
        logic [31:0] t1, t2, s0, s1;
        hash_t h_out;
        for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = h_in[255 - 32*i -: 32];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_k(i[5:0]) + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            h_out[255 - 32*i -: 32] = h_in[255 - 32*i -: 32] + v[i];
        return h_out;
    endfunction

    // 60-byte record message, padded to two blocks; byte j at [1023-8j -: 8]
    function automatic hash_t record_digest(logic [63:0] seq, logic [63:0] stamp,
                                            hash_t prev, logic [31:0] agent,
                                            logic [31:0] action, logic [31:0] outcome);
        logic [1023:0] msg;
        hash_t h;
        msg = '0;
        for (int j = 0; j < 8; j++) begin
            msg[1023 - 8*j -: 8]      = seq[8*j +: 8];
            msg[1023 - 8*(8+j) -: 8]  = stamp[8*j +: 8];
        end
        msg[1023 - 8*16 -: 256] = prev;
        for (int j = 0; j < 4; j++) begin
            msg[1023 - 8*(48+j) -: 8] = agent[8*j +: 8];
            msg[1023 - 8*(52+j) -: 8] = action[8*j +: 8];
            msg[1023 - 8*(56+j) -: 8] = outcome[8*j +: 8];
        end
        msg[1023 - 8*60 -: 8] = 8'h80;
        msg[63:0] = 64'd480;
        h = compress(SHA_IV, msg[1023:512]);
        return compress(h, msg[511:0]);
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        n_errors++;
        $display("[%0t] %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // chain model: advance on every accepted record
    always @(posedge aclk) begin
        entry_t e;
        if (aresetn && s_valid && s_ready) begin
            e.seq    = model_seq;
            e.digest = record_digest(model_seq, s_stamp_ns, model_head, s_agent_number,
                                     s_action_number, s_outcome_value);
            pending_digests.push_back(e);
            model_head = e.digest;
            model_seq  = model_seq + 64'd1;
        end
    end

    always @(posedge aclk) begin
        entry_t e;
        if (aresetn && m_valid && m_ready) begin
            seen_seq.push_back(m_record_sequence);
            if (pending_digests.size() == 0) begin
                report("unexpected transaction, seq", m_record_sequence, 64'h0);
            end else begin
                e = pending_digests.pop_front();
                n_checked++;
                if (m_record_sequence !== e.seq)
                    report("record_sequence", m_record_sequence, e.seq);
                if (m_digest_word0 !== e.digest[255:192])
                    report("digest_word0", m_digest_word0, e.digest[255:192]);
                if (m_digest_word1 !== e.digest[191:128])
                    report("digest_word1", m_digest_word1, e.digest[191:128]);
                if (m_digest_word2 !== e.digest[127:64])
                    report("digest_word2", m_digest_word2, e.digest[127:64]);
                if (m_digest_word3 !== e.digest[63:0])
                    report("digest_word3", m_digest_word3, e.digest[63:0]);
            end
        end
    end

    // receiver
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off_req) begin
                stall = LONG_HOLD;
                hold_off_req = 1'b0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 10);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic send(logic [31:0] agent, logic [31:0] action,
                        logic [31:0] outcome, logic [63:0] stamp);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_agent_number  <= agent;
        s_action_number <= action;
        s_outcome_value <= outcome;
        s_stamp_ns      <= stamp;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hffffffff;
            2: return 32'h80000000;
            3: return 32'h7fffffff;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_agent_number  = '0;
        s_action_number = '0;
        s_outcome_value = '0;
        s_stamp_ns      = '0;
        model_head      = '0;
        model_seq       = '0;
        n_errors        = 0;
        n_sent          = 0;
        n_checked       = 0;
        cycle_count     = 0;
        hold_off_req    = 1'b0;
        no_idle         = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            send(directed[i].agent, directed[i].action, directed[i].outcome,
                 directed[i].stamp);
        end
        // wait for directed results, then check sequence numbers as typed in
        while (n_checked < directed.size()) @(posedge aclk);
        foreach (directed[i])
            if (seen_seq[i] !== directed[i].seq_exp)
                report("directed sequence", seen_seq[i], directed[i].seq_exp);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 100) hold_off_req = 1'b1;
            no_idle = (i >= 400 && i < 480);
            send(rand_word(), rand_word(), rand_word(),
                 {rand_word(), rand_word()});
        end
        s_valid <= 1'b0;
        no_idle = 1'b0;

        while (pending_digests.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Sent %0d records (%0d directed), checked %0d chained digests",
                 n_sent, directed.size(), n_checked);
        $display("Included a %0d-cycle receiver hold-off and a back-to-back stretch",
                 LONG_HOLD);
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/shc_pkg.sv
hw/rtl/shc_fifo.sv
hw/rtl/shc_engine.sv
hw/rtl/sha256_hash_chain_log_appender.sv
hw/rtl/shc_checker.sv
tb/tb_sha256_hash_chain_log_appender.sv
